// ----- hw/rtl/htfr_pkg.sv -----
// ----------------------------------------------------------------------------
// htfr_pkg
// shared constants and controller/datapath handshake types of the frame
// receiver
// ----------------------------------------------------------------------------
package htfr_pkg;

  localparam int FRAME_MAX_DEF = 16;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 4;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hA5;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5A;
  localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] TRL_SECOND = 8'h55;

  // controller to datapath
  typedef struct packed {
    logic take;     // input beat accepted
    logic rd;       // read frame store at current output position
    logic advance;  // output beat accepted
  } htfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;     // current input completes a frame
    logic ovf;      // current input overruns the frame store
    logic last;     // shown result is the final one of the run
  } htfr_sts_t;

endpackage

// ----- hw/rtl/htfr_in_if.sv -----
// ----------------------------------------------------------------------------
// htfr_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface htfr_in_if;
  logic                           valid;
  logic                           ready;
  logic [htfr_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/htfr_out_if.sv -----
// ----------------------------------------------------------------------------
// htfr_out_if
// frame result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface htfr_out_if;
  logic                           valid;
  logic                           ready;
  logic [htfr_pkg::BYTE_W-1:0]    frame_byte;
  logic [htfr_pkg::IDX_W-1:0]     byte_index;
  logic                           last_byte;
  logic                           overflow;

  modport source (output valid, output frame_byte, output byte_index,
                  output last_byte, output overflow, input ready);
  modport sink   (input valid, input frame_byte, input byte_index,
                  input last_byte, input overflow, output ready);
endinterface

// ----- hw/rtl/htfr_ram.sv -----
// ----------------------------------------------------------------------------
// htfr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module htfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/htfr_datapath.sv -----
// ----------------------------------------------------------------------------
// htfr_datapath
// byte history, frame state, frame store and result formatting
// ----------------------------------------------------------------------------
module htfr_datapath #(
  parameter int FRAME_MAX = htfr_pkg::FRAME_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  htfr_pkg::htfr_cmd_t         cmd,
  output htfr_pkg::htfr_sts_t         sts,
  input  logic [htfr_pkg::BYTE_W-1:0] rx_byte,
  output logic [htfr_pkg::BYTE_W-1:0] frame_byte,
  output logic [htfr_pkg::IDX_W-1:0]  byte_index,
  output logic                        last_byte,
  output logic                        overflow
);

  localparam int AW  = $clog2(FRAME_MAX);
  localparam int WIW = $clog2(FRAME_MAX + 1);
  localparam int BW  = htfr_pkg::BYTE_W;
  localparam int IW  = htfr_pkg::IDX_W;

  logic           in_frame_r, in_frame_nxt;
  logic [BW-1:0]  prev_r, prev_nxt;
  logic [BW-1:0]  pprev_r, pprev_nxt;
  logic [WIW-1:0] wi_r, wi_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  last_idx_r, last_idx_nxt;
  logic           ovf_r, ovf_nxt;

  logic           hdr_hit;
  logic           fr_open;
  logic [WIW-1:0] wi_eff;
  logic           ovf_hit;
  logic           wr_hit;
  logic           trl_hit;
  logic [BW-1:0]  ram_q;
  logic [IW+AW-1:0] cnt_ext;

  assign hdr_hit = !in_frame_r && (prev_r == htfr_pkg::HDR_SECOND)
                   && (pprev_r == htfr_pkg::HDR_FIRST);
  assign fr_open = in_frame_r || hdr_hit;
  assign wi_eff  = in_frame_r ? wi_r : WIW'(2);
  assign ovf_hit = fr_open && (wi_eff >= WIW'(FRAME_MAX));
  assign wr_hit  = fr_open && !ovf_hit;
  // previous stored byte always equals the previous input while in frame
  assign trl_hit = wr_hit && (rx_byte == htfr_pkg::TRL_SECOND)
                   && (prev_r == htfr_pkg::TRL_FIRST);

  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_nxt     = prev_r;
    pprev_nxt    = pprev_r;
    wi_nxt       = wi_r;
    cnt_nxt      = cnt_r;
    last_idx_nxt = last_idx_r;
    ovf_nxt      = ovf_r;
    if (cmd.take) begin
      in_frame_nxt = wr_hit && !trl_hit;
      wi_nxt       = (wr_hit && !trl_hit) ? wi_eff + WIW'(1) : WIW'(2);
      pprev_nxt    = prev_r;
      prev_nxt     = rx_byte;
      cnt_nxt      = '0;
      last_idx_nxt = wi_eff[AW-1:0];
      ovf_nxt      = ovf_hit;
    end else if (cmd.advance) begin
      cnt_nxt = cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= '0;
      pprev_r    <= '0;
      wi_r       <= WIW'(2);
      cnt_r      <= '0;
      last_idx_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      prev_r     <= prev_nxt;
      pprev_r    <= pprev_nxt;
      wi_r       <= wi_nxt;
      cnt_r      <= cnt_nxt;
      last_idx_r <= last_idx_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // header positions come from constants, the rest from the store
  htfr_ram #(
    .WIDTH (BW),
    .DEPTH (FRAME_MAX)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take && wr_hit),
    .waddr (wi_eff[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd),
    .raddr (cnt_r),
    .rdata (ram_q)
  );

  assign cnt_ext = {{IW{1'b0}}, cnt_r};

  always_comb begin
    if (ovf_r) begin
      frame_byte = '0;
    end else if (cnt_r == AW'(0)) begin
      frame_byte = htfr_pkg::HDR_FIRST;
    end else if (cnt_r == AW'(1)) begin
      frame_byte = htfr_pkg::HDR_SECOND;
    end else begin
      frame_byte = ram_q;
    end
  end

  assign byte_index = ovf_r ? '0 : cnt_ext[IW-1:0];
  assign last_byte  = ovf_r || (cnt_r == last_idx_r);
  assign overflow   = ovf_r;

  assign sts.emit = trl_hit;
  assign sts.ovf  = ovf_hit;
  assign sts.last = last_byte;

endmodule

// ----- hw/rtl/htfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// htfr_ctrl
// controller: takes a byte; on a completed frame walks the frame store one result at a time
// ----------------------------------------------------------------------------
module htfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  htfr_pkg::htfr_sts_t sts,
  output htfr_pkg::htfr_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign cmd.take    = in_valid && in_ready_r;
  assign cmd.rd      = (state_r == ST_READ);
  assign cmd.advance = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          in_ready_r <= 1'b1;
          if (cmd.take) begin
            if (sts.ovf) begin
              state_r     <= ST_SHOW;
              in_ready_r  <= 1'b0;
              out_valid_r <= 1'b1;
            end else if (sts.emit) begin
              state_r    <= ST_READ;
              in_ready_r <= 1'b0;
            end
          end
        end
        ST_READ: begin
          state_r     <= ST_SHOW;
          out_valid_r <= 1'b1;
        end
        ST_SHOW: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (sts.last) begin
              state_r    <= ST_IDLE;
              in_ready_r <= 1'b1;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/header_tail_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// header_tail_frame_receiver_core
// deframer for a received byte stream with a two byte header and trailer
// ----------------------------------------------------------------------------
// An input byte is taken on an in_ch handshake. A byte that completes a frame
// (header 0xA5 0x5A, trailer 0xAA 0x55) is followed by one result per frame
// byte, header first, each made by a frame store read and then shown on the
// output until out_ch.ready takes it; no byte is taken until the last result
// is delivered. A frame that would exceed FRAME_MAX bytes gives one overflow
// result. The frame store is a ram of FRAME_MAX bytes with one write and one
// registered read port; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module header_tail_frame_receiver_core #(
  parameter int FRAME_MAX = htfr_pkg::FRAME_MAX_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  htfr_in_if.sink    in_ch,
  htfr_out_if.source out_ch
);

  htfr_pkg::htfr_cmd_t cmd;
  htfr_pkg::htfr_sts_t sts;

  htfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  htfr_datapath #(
    .FRAME_MAX (FRAME_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .rx_byte    (in_ch.rx_byte),
    .frame_byte (out_ch.frame_byte),
    .byte_index (out_ch.byte_index),
    .last_byte  (out_ch.last_byte),
    .overflow   (out_ch.overflow)
  );

endmodule

// ----- hw/rtl/htfr_checker.sv -----
// ----------------------------------------------------------------------------
// htfr_checker
// port level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module htfr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [htfr_pkg::BYTE_W-1:0] frame_byte,
  input logic [htfr_pkg::IDX_W-1:0]  byte_index,
  input logic                        last_byte,
  input logic                        overflow
);

  // output beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped before accept");

  // no byte taken while results are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // overflow beat is a single final beat with zero payload
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> last_byte && frame_byte == '0 && byte_index == '0)
    else $error("malformed overflow beat");

  // a run of results ends with a last beat before input resumes
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_byte |=> !in_ready)
    else $error("input resumed before last beat");

endmodule

bind header_tail_frame_receiver_core htfr_checker u_htfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .frame_byte (out_ch.frame_byte),
  .byte_index (out_ch.byte_index),
  .last_byte  (out_ch.last_byte),
  .overflow   (out_ch.overflow)
);
